### rtl/hetm_pkg.sv
// Shared constants, codes and types for the exposure / LUT tone mapper.
package hetm_pkg;

  localparam int LUT_SIZE = 4096;
  localparam int LUT_AW   = $clog2(LUT_SIZE);

  localparam int COMP_W   = 32;
  localparam int GAIN_W   = 32;
  localparam int VAL_W    = 8;
  localparam int EIDX_W   = 12;
  localparam int FRAC_W   = 16;

  localparam int PROD_W   = COMP_W - 1 + GAIN_W;
  localparam int CUT_W    = PROD_W - FRAC_W;
  localparam int SAT_W    = FRAC_W + 1;
  localparam int T_W      = SAT_W + LUT_AW;

  localparam logic [SAT_W-1:0]  UNITY      = SAT_W'(1) << FRAC_W;
  localparam logic [FRAC_W-1:0] HALF       = FRAC_W'(1) << (FRAC_W - 1);
  localparam logic [LUT_AW-1:0] LUT_MAX    = LUT_AW'(LUT_SIZE - 1);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_W;

  typedef enum logic {
    ACT_MAP   = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  // Control that travels beside the arithmetic lanes.
  typedef struct packed {
    logic              valid;
    logic              wr;
    logic              wr_en;
    logic [LUT_AW-1:0] waddr;
    logic [VAL_W-1:0]  wval;
  } ctl_t;

endpackage

### rtl/hetm_ifs.sv
// Channel interfaces: pixel/table-write input, mapped pixel output, gain write.
interface hetm_in_if;
  import hetm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [COMP_W-1:0] red_in;
  logic signed [COMP_W-1:0] green_in;
  logic signed [COMP_W-1:0] blue_in;
  logic [EIDX_W-1:0]        entry_index;
  logic [VAL_W-1:0]         entry_value;

  modport source (output valid, action, red_in, green_in, blue_in, entry_index,
                  entry_value, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, entry_index,
                  entry_value, output ready);
endinterface

interface hetm_out_if;
  import hetm_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] red_out;
  logic [VAL_W-1:0] green_out;
  logic [VAL_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface hetm_cfg_if;
  import hetm_pkg::*;
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] exposure_gain;

  modport source (output valid, exposure_gain, input ready);
  modport sink   (input valid, exposure_gain, output ready);
endinterface

### rtl/hetm_lane.sv
// One color component: gain multiply, saturate and scale, round to a table index.
module hetm_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [hetm_pkg::COMP_W-1:0] comp,
  input  logic [hetm_pkg::GAIN_W-1:0]        gain,
  output logic [hetm_pkg::LUT_AW-1:0]        idx
);
  import hetm_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    t;
  logic              pos;
  logic [CUT_W-1:0]  v;
  logic [SAT_W-1:0]  sat;
  logic [LUT_AW:0]   q;
  logic [LUT_AW:0]   qr;
  logic [FRAC_W-1:0] rem;
  logic              up;

  // stage 1: Q15.16 x Q16.16, only positive components count
  assign pos = !comp[COMP_W-1] && (comp != '0);

  // stage 2: truncate to Q1.16 with a clamp at 1.0, scale by LUT_SIZE-1
  assign v   = prod[PROD_W-1:FRAC_W];
  assign sat = (v > CUT_W'(UNITY)) ? UNITY : v[SAT_W-1:0];

  // stage 3: round half to even
  assign q   = t[T_W-1:FRAC_W];
  assign rem = t[FRAC_W-1:0];
  assign up  = (rem > HALF) || ((rem == HALF) && q[0]);
  assign qr  = q + (LUT_AW+1)'(up);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= pos ? PROD_W'(comp[COMP_W-2:0]) * PROD_W'(gain) : '0;
      t    <= T_W'(sat) * T_W'(LUT_SIZE - 1);
      idx  <= (qr > (LUT_AW+1)'(LUT_MAX)) ? LUT_MAX : qr[LUT_AW-1:0];
    end
  end

endmodule

### rtl/hetm_lut.sv
// One copy of the transfer table: one write port, one registered read port.
module hetm_lut (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [hetm_pkg::LUT_AW-1:0] waddr,
  input  logic [hetm_pkg::VAL_W-1:0]  wdata,
  input  logic [hetm_pkg::LUT_AW-1:0] raddr,
  output logic [hetm_pkg::VAL_W-1:0]  rdata
);
  import hetm_pkg::*;

  logic [VAL_W-1:0] mem [LUT_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/hdr_exposure_lut_tone_map_unit.sv
// Top level: HDR exposure, clamp and table lookup tone mapping pipeline.
// Path: an accepted pixel passes three arithmetic stages per lane, then the registered
// table read, and is then held on dst while dst stalls.
// Throughput: one transaction per cycle, pixel or table write; the whole pipe
// advances together when the output register holds no pixel or is being taken.
// Reset: rst (synchronous) clears all valid bits and sets the gain to 1.0;
// table contents are undefined until written. No clearing pass.
module hdr_exposure_lut_tone_map_unit (
  input  logic       clk,
  input  logic       rst,
  hetm_in_if.sink    src,
  hetm_out_if.source dst,
  hetm_cfg_if.sink   cfg
);
  import hetm_pkg::*;

  logic [GAIN_W-1:0] gain;
  ctl_t              s1, s2, s3, s4;
  ctl_t              s0;
  logic              adv;
  logic              we;
  logic [LUT_AW-1:0] ridx [3];
  logic [VAL_W-1:0]  rdat [3];
  logic signed [COMP_W-1:0] comp [3];

  assign adv       = !(s4.valid && !s4.wr) || dst.ready;
  assign src.ready = adv;
  assign cfg.ready = 1'b1;

  assign s0.valid = src.valid;
  assign s0.wr    = (src.action == ACT_WRITE);
  assign s0.wr_en = (src.action == ACT_WRITE) && (32'(src.entry_index) < LUT_SIZE);
  assign s0.waddr = LUT_AW'(src.entry_index);
  assign s0.wval  = src.entry_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg.valid) begin
      gain <= cfg.exposure_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else if (adv) begin
      s1 <= s0;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
    end
  end

  // table written as the write transaction leaves stage 3, so order is kept
  assign we = adv && s3.valid && s3.wr_en;

  assign comp[0] = src.red_in;
  assign comp[1] = src.green_in;
  assign comp[2] = src.blue_in;

  for (genvar i = 0; i < 3; i++) begin : g_chan
    hetm_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .comp (comp[i]),
      .gain (gain),
      .idx  (ridx[i])
    );

    hetm_lut u_lut (
      .clk   (clk),
      .en    (adv),
      .we    (we),
      .waddr (s3.waddr),
      .wdata (s3.wval),
      .raddr (ridx[i]),
      .rdata (rdat[i])
    );
  end

  assign dst.valid     = s4.valid && !s4.wr;
  assign dst.red_out   = rdat[0];
  assign dst.green_out = rdat[1];
  assign dst.blue_out  = rdat[2];

`ifndef SYNTHESIS
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (adv && s2.valid) |=> s3.valid)
    else $error("transaction lost between stage 2 and stage 3");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s1) && $stable(s2) && $stable(s3)))
    else $error("pipeline moved during a stall");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (adv && s3.valid && s3.wr) |=> !dst.valid)
    else $error("table write produced an output");
`endif

endmodule
